>>> rtl/pressure_temperature_compensation_macros.svh
// assertion macros shared by the compensation block
// expects clk and rst in the scope of each use
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_MACROS_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_MACROS_SVH

// condition must hold at every edge out of reset
`define PTC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence must hold in the cycle after the antecedent
`define PTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ptc_pkg.sv
// types and constants of the pressure/temperature compensation pipeline
// used by every module of the block, no dependencies
`default_nettype none

package ptc_pkg;

  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 64;
  localparam int DIV_W          = 64;
  localparam int X1_OFFSET      = 128000;
  localparam int P_FULL_SCALE   = 1048576;
  localparam int DIV_SCALE      = 3125;
  localparam int CAL_BASE_SHIFT = 47;
  localparam int DEN_SHIFT      = 33;
  localparam int CENTI_ROUND    = 128;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CALIB_TEMP    = 2'd0,
    CFG_CALIB_PRESS_A = 2'd1,
    CFG_CALIB_PRESS_B = 2'd2,
    CFG_CALIB_PRESS_C = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } calib_t;

  typedef struct packed {
    logic signed [31:0] centi;
    logic signed [31:0] fine;
    logic signed [33:0] x1;
    logic        [19:0] adc_p;
  } temp_res_t;

  typedef struct packed {
    logic signed [31:0] centi;
    logic signed [31:0] fine;
    logic               neg;
    logic               invalid;
  } div_side_t;

  typedef struct packed {
    div_side_t          side;
    logic [DIV_W-1:0]   num_mag;
    logic [DIV_W-1:0]   den_mag;
  } div_in_t;

  typedef struct packed {
    div_side_t          side;
    logic [DIV_W-1:0]   quo_mag;
  } div_out_t;

  typedef struct packed {
    logic signed [31:0] centi;
    logic signed [31:0] fine;
    logic        [31:0] press;
    logic               invalid;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/ptc_temp.sv
// temperature stages: fine temperature, centidegrees and pressure offset term
// depends on ptc_pkg
`default_nettype none

module ptc_temp (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  en,
  input  wire                  vld_in,
  input  wire  [19:0]          raw_t,
  input  wire  [19:0]          raw_p,
  input  ptc_pkg::calib_t      cal,
  output logic                 vld_out,
  output ptc_pkg::temp_res_t   res
);
  import ptc_pkg::*;

  logic               vld1, vld2, vld3, vld4;
  logic signed [17:0] a1, d1;
  logic        [19:0] adc_p1, adc_p2, adc_p3, adc_p4;
  logic signed [31:0] m1, dd2, v1, m2, fine4;
  logic signed [17:0] a_c, d_c;
  logic signed [31:0] sqr;

  assign a_c = $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
  assign d_c = $signed({2'b0, raw_t[19:4]}) - $signed({2'b0, cal.t1});
  assign sqr = dd2 >>> 12;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      vld3    <= 1'b0;
      vld4    <= 1'b0;
      vld_out <= 1'b0;
    end else if (en) begin
      vld1    <= vld_in;
      vld2    <= vld1;
      vld3    <= vld2;
      vld4    <= vld3;
      vld_out <= vld4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1        <= a_c;
      d1        <= d_c;
      adc_p1    <= raw_p;
      m1        <= 32'(34'(a1) * 34'(cal.t2));
      dd2       <= 32'(36'(d1) * 36'(d1));
      adc_p2    <= adc_p1;
      v1        <= m1 >>> 11;
      m2        <= sqr * 32'(cal.t3);
      adc_p3    <= adc_p2;
      fine4     <= v1 + (m2 >>> 14);
      adc_p4    <= adc_p3;
      res.centi <= ((fine4 <<< 2) + fine4 + 32'(CENTI_ROUND)) >>> 8;
      res.fine  <= fine4;
      res.x1    <= 34'(fine4) - 34'(X1_OFFSET);
      res.adc_p <= adc_p4;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ptc_prep.sv
// pressure stages ahead of the divider: numerator, denominator, sign split
// depends on ptc_pkg
`default_nettype none

module ptc_prep (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  en,
  input  wire                  vld_in,
  input  ptc_pkg::temp_res_t   din,
  input  ptc_pkg::calib_t      cal,
  output logic                 vld_out,
  output ptc_pkg::div_in_t     dout
);
  import ptc_pkg::*;

  logic               vld1, vld2, vld3, vld4, vld5;
  logic signed [31:0] centi1, centi2, centi3, centi4, centi5;
  logic signed [31:0] fine1, fine2, fine3, fine4, fine5;
  logic        [19:0] adc_p1, adc_p2, adc_p3;
  logic signed [63:0] xx, xp5a, xp2a, a6, a3, xp5b, xp2b, x2, x1c, ym, nd, den, num;
  logic        [20:0] pp;

  assign pp = 21'(P_FULL_SCALE) - {1'b0, adc_p3};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      vld3    <= 1'b0;
      vld4    <= 1'b0;
      vld5    <= 1'b0;
      vld_out <= 1'b0;
    end else if (en) begin
      vld1    <= vld_in;
      vld2    <= vld1;
      vld3    <= vld2;
      vld4    <= vld3;
      vld5    <= vld4;
      vld_out <= vld5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xx     <= 64'(68'(din.x1) * 68'(din.x1));
      xp5a   <= 64'(50'(din.x1) * 50'(cal.p5));
      xp2a   <= 64'(50'(din.x1) * 50'(cal.p2));
      centi1 <= din.centi;
      fine1  <= din.fine;
      adc_p1 <= din.adc_p;

      a6     <= xx * 64'(cal.p6);
      a3     <= xx * 64'(cal.p3);
      xp5b   <= xp5a;
      xp2b   <= xp2a;
      centi2 <= centi1;
      fine2  <= fine1;
      adc_p2 <= adc_p1;

      x2     <= a6 + (xp5b <<< 17) + (64'(cal.p4) <<< 35);
      x1c    <= (64'sd1 <<< CAL_BASE_SHIFT) + (a3 >>> 8) + (xp2b <<< 12);
      centi3 <= centi2;
      fine3  <= fine2;
      adc_p3 <= adc_p2;

      ym     <= x1c * $signed({48'd0, cal.p1});
      nd     <= ($signed({43'd0, pp}) <<< 31) - x2;
      centi4 <= centi3;
      fine4  <= fine3;

      den    <= ym >>> DEN_SHIFT;
      num    <= nd * 64'(DIV_SCALE);
      centi5 <= centi4;
      fine5  <= fine4;

      dout.side.centi   <= centi5;
      dout.side.fine    <= fine5;
      dout.side.neg     <= num[63] ^ den[63];
      dout.side.invalid <= (den == 64'sd0);
      dout.num_mag      <= num[63] ? 64'(-num) : 64'(num);
      dout.den_mag      <= den[63] ? 64'(-den) : 64'(den);
    end
  end

endmodule

`default_nettype wire

>>> rtl/ptc_div.sv
// unsigned restoring divider, one quotient bit per pipeline stage
// depends on ptc_pkg
`default_nettype none

module ptc_div (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  en,
  input  wire                  vld_in,
  input  ptc_pkg::div_in_t     din,
  output logic                 vld_out,
  output ptc_pkg::div_out_t    dout
);
  import ptc_pkg::*;

  logic             vld  [0:DIV_W];
  logic [DIV_W-1:0] rem  [0:DIV_W];
  logic [DIV_W-1:0] nq   [0:DIV_W];
  logic [DIV_W-1:0] dv   [0:DIV_W];
  div_side_t        side [0:DIV_W];

  assign vld[0]  = vld_in;
  assign rem[0]  = '0;
  assign nq[0]   = din.num_mag;
  assign dv[0]   = din.den_mag;
  assign side[0] = din.side;

  for (genvar g = 0; g < DIV_W; g++) begin : g_stage
    logic [DIV_W-1:0] trial;
    logic             ge;

    // remainder stays below the divisor magnitude, so the shift never overflows
    assign trial = {rem[g][DIV_W-2:0], nq[g][DIV_W-1]};
    assign ge    = (trial >= dv[g]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g+1]  <= ge ? trial - dv[g] : trial;
        nq[g+1]   <= {nq[g][DIV_W-2:0], ge};
        dv[g+1]   <= dv[g];
        side[g+1] <= side[g];
      end
    end
  end

  assign vld_out      = vld[DIV_W];
  assign dout.side    = side[DIV_W];
  assign dout.quo_mag = nq[DIV_W];

endmodule

`default_nettype wire

>>> rtl/ptc_post.sv
// pressure stages after the divider: sign, second-order correction, saturation
// depends on ptc_pkg
`default_nettype none

module ptc_post (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  en,
  input  wire                  vld_in,
  input  ptc_pkg::div_out_t    din,
  input  ptc_pkg::calib_t      cal,
  output logic                 vld_out,
  output ptc_pkg::result_t     res
);
  import ptc_pkg::*;

  logic               vld1, vld2, vld3, vld4, vld5, vld6;
  div_side_t          sd1, sd2, sd3, sd4, sd5, sd6;
  logic signed [63:0] q1, q2, q3, q4, ph, ph2, mp9, y2m, y2a, y2b, yy, s5, pf;
  logic        [63:0] ll;
  logic        [31:0] cr;

  assign ph = q1 >>> 13;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      vld3    <= 1'b0;
      vld4    <= 1'b0;
      vld5    <= 1'b0;
      vld6    <= 1'b0;
      vld_out <= 1'b0;
    end else if (en) begin
      vld1    <= vld_in;
      vld2    <= vld1;
      vld3    <= vld2;
      vld4    <= vld3;
      vld5    <= vld4;
      vld6    <= vld5;
      vld_out <= vld6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1  <= din.side.neg ? -$signed(din.quo_mag) : $signed(din.quo_mag);
      sd1 <= din.side;

      mp9 <= 64'(cal.p9) * ph;
      y2m <= 64'(cal.p8) * q1;
      ph2 <= ph;
      q2  <= q1;
      sd2 <= sd1;

      // low 64 bits of mp9 * ph from 32-bit partial products
      ll  <= {32'd0, mp9[31:0]} * {32'd0, ph2[31:0]};
      cr  <= 32'(mp9[31:0] * ph2[63:32]) + 32'(mp9[63:32] * ph2[31:0]);
      y2a <= y2m >>> 19;
      q3  <= q2;
      sd3 <= sd2;

      yy  <= $signed(ll + {cr, 32'd0});
      y2b <= y2a;
      q4  <= q3;
      sd4 <= sd3;

      s5  <= q4 + (yy >>> 25) + y2b;
      sd5 <= sd4;

      pf  <= (s5 >>> 8) + (64'(cal.p7) <<< 4);
      sd6 <= sd5;

      res.centi   <= sd6.centi;
      res.fine    <= sd6.fine;
      res.invalid <= sd6.invalid;
      if (sd6.invalid || pf[63]) begin
        res.press <= '0;
      end else if (|pf[62:32]) begin
        res.press <= '1;
      end else begin
        res.press <= pf[31:0];
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/pressure_temperature_compensation.sv
// top level of the barometric pressure/temperature compensation pipeline
// depends on ptc_pkg, ptc_temp, ptc_prep, ptc_div, ptc_post and the macro header
//
// usage:
//  - calibration words are loaded through cfg_we/cfg_index/cfg_data, one
//    register per write, while no item is in flight
//  - a raw temperature/pressure pair transfers when in_valid is high and
//    in_stall is low; one result transfers when out_valid is high and
//    out_stall is low
//  - the datapath is an 82-stage pipeline: 5 temperature stages, 6 pressure
//    setup stages, 64 divider stages (one quotient bit each) and 7 final
//    stages
//  - throughput is one pair per clock unless stalled; all stages move together
//  - when the receiver stalls a waiting result, every stage holds and
//    in_stall rises in the same cycle; nothing is dropped or repeated
//  - a divisor of zero gives pressure 0 with pressure_invalid set
//  - reset clears all valid bits and the calibration registers to zero
`include "pressure_temperature_compensation_macros.svh"
`default_nettype none

module pressure_temperature_compensation (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire  [ptc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [ptc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [19:0]                  raw_temperature,
  input  wire  [19:0]                  raw_pressure,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic signed [31:0]           temperature_centi,
  output logic signed [31:0]           fine_temperature,
  output logic [31:0]                  pressure_q24_8,
  output logic                         pressure_invalid
);
  import ptc_pkg::*;

  logic [47:0] calib_temp;
  logic [63:0] calib_press_a;
  logic [63:0] calib_press_b;
  logic [15:0] calib_press_c;
  calib_t      cal;
  logic        adv;
  logic        temp_vld, prep_vld, div_vld;
  temp_res_t   temp_res;
  div_in_t     div_in;
  div_out_t    div_out;
  result_t     res;

  always_ff @(posedge clk) begin
    if (rst) begin
      calib_temp    <= '0;
      calib_press_a <= '0;
      calib_press_b <= '0;
      calib_press_c <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CALIB_TEMP:    calib_temp    <= cfg_data[47:0];
        CFG_CALIB_PRESS_A: calib_press_a <= cfg_data;
        CFG_CALIB_PRESS_B: calib_press_b <= cfg_data;
        CFG_CALIB_PRESS_C: calib_press_c <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cal.t1 = calib_temp[15:0];
    cal.t2 = $signed(calib_temp[31:16]);
    cal.t3 = $signed(calib_temp[47:32]);
    cal.p1 = calib_press_a[15:0];
    cal.p2 = $signed(calib_press_a[31:16]);
    cal.p3 = $signed(calib_press_a[47:32]);
    cal.p4 = $signed(calib_press_a[63:48]);
    cal.p5 = $signed(calib_press_b[15:0]);
    cal.p6 = $signed(calib_press_b[31:16]);
    cal.p7 = $signed(calib_press_b[47:32]);
    cal.p8 = $signed(calib_press_b[63:48]);
    cal.p9 = $signed(calib_press_c);
  end

  // the pipeline advances unless a finished result is held by the receiver
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  ptc_temp u_temp (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .vld_in  (in_valid),
    .raw_t   (raw_temperature),
    .raw_p   (raw_pressure),
    .cal     (cal),
    .vld_out (temp_vld),
    .res     (temp_res)
  );

  ptc_prep u_prep (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .vld_in  (temp_vld),
    .din     (temp_res),
    .cal     (cal),
    .vld_out (prep_vld),
    .dout    (div_in)
  );

  ptc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .vld_in  (prep_vld),
    .din     (div_in),
    .vld_out (div_vld),
    .dout    (div_out)
  );

  ptc_post u_post (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .vld_in  (div_vld),
    .din     (div_out),
    .cal     (cal),
    .vld_out (out_valid),
    .res     (res)
  );

  assign temperature_centi = res.centi;
  assign fine_temperature  = res.fine;
  assign pressure_q24_8    = res.press;
  assign pressure_invalid  = res.invalid;

  `PTC_ASSERT_ALWAYS(a_invalid_zero, !(out_valid && pressure_invalid) || (pressure_q24_8 == 32'd0), "invalid result with nonzero pressure")
  `PTC_ASSERT_ALWAYS(a_no_stall_when_empty, out_valid || !in_stall, "input stalled with empty output")
  `PTC_ASSERT_NEXT(a_cfg_c_write, cfg_we && (cfg_index == CFG_CALIB_PRESS_C), calib_press_c == $past(cfg_data[15:0]), "calibration write lost")

endmodule

`default_nettype wire
